>>> design/pac_pkg.sv
// ----------------------------------------------------------------------------
// pac_pkg
// Types and constants shared by the pileup allele counter.
// ----------------------------------------------------------------------------
package pac_pkg;

  localparam int SITE_DEPTH_LIMIT = 1024;
  localparam int DEPTH_W   = 11;
  localparam int CNT_W     = 11;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W     = 2;
  localparam int FCNT_W    = 3;

  localparam logic [7:0]       QUAL_CAP  = 8'd64;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  localparam logic [2:0] ALLELE_C    = 3'd1;
  localparam logic [2:0] ALLELE_G    = 3'd2;
  localparam logic [2:0] ALLELE_NONE = 3'd4;

  localparam logic [3:0] CODE_A = 4'd1;
  localparam logic [3:0] CODE_C = 4'd2;
  localparam logic [3:0] CODE_G = 4'd4;
  localparam logic [3:0] CODE_T = 4'd8;

  localparam logic [1:0] STATE_UNKNOWN = 2'd0;
  localparam logic [1:0] STATE_REF     = 2'd1;
  localparam logic [1:0] STATE_ALT     = 2'd2;

  localparam logic OP_BASE  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic CFG_MIN_QUAL   = 1'b0;
  localparam logic CFG_OUTGROUP_EN = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] chrom_index;
    logic [31:0] position;
    logic [1:0]  ref_base;
    logic [2:0]  chimp_allele;
    logic [2:0]  ancestor_allele;
    logic        outgroup_cpg;
    logic [3:0]  base_code;
    logic [7:0]  base_qual;
    logic        is_gap;
    logic        last_of_site;
  } in_beat_t;

  typedef struct packed {
    logic [15:0]      out_chrom;
    logic [31:0]      out_position;
    logic [1:0]       out_ref;
    logic [2:0]       out_alt;
    logic [1:0]       root_state;
    logic             root_cpg;
    logic [1:0]       anc_state;
    logic             anc_cpg;
    logic [CNT_W-1:0] ref_count;
    logic [CNT_W-1:0] alt_count;
    logic             sample_cpg;
    logic             last;
  } out_beat_t;

  typedef struct packed {
    logic [15:0]      chrom;
    logic [31:0]      pos;
    logic [1:0]       ref_b;
    logic [2:0]       alt;
    logic [1:0]       rs;
    logic             rc;
    logic [1:0]       as_st;
    logic             ac;
    logic [CNT_W-1:0] nref;
    logic [CNT_W-1:0] nalt;
  } rec_t;

  typedef struct packed {
    logic [1:0] n;
    out_beat_t  beat0;
    out_beat_t  beat1;
  } push_t;

  typedef struct packed {
    logic [7:0] min_base_qual;
    logic       outgroup_enabled;
  } cfg_t;

  function automatic out_beat_t make_beat(rec_t r, logic cpg, logic last);
    out_beat_t b;
    b.out_chrom    = r.chrom;
    b.out_position = r.pos;
    b.out_ref      = r.ref_b;
    b.out_alt      = r.alt;
    b.root_state   = r.rs;
    b.root_cpg     = r.rc;
    b.anc_state    = r.as_st;
    b.anc_cpg      = r.ac;
    b.ref_count    = r.nref;
    b.alt_count    = r.nalt;
    b.sample_cpg   = cpg;
    b.last         = last;
    return b;
  endfunction

endpackage

>>> design/pac_site.sv
// ----------------------------------------------------------------------------
// pac_site
// Site accumulator: base filtering, ref/alt counting, outgroup resolution and
// the one-record hold for CpG pairing.
// ----------------------------------------------------------------------------
module pac_site import pac_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     item_valid_i,
  input  in_beat_t item_i,
  input  cfg_t     cfg_i,
  output push_t    push_o
);

  typedef struct packed {
    logic       ok;
    logic [2:0] alt;
    logic [1:0] state;
    logic       flag;
  } res_t;

  function automatic res_t resolve(logic [2:0] allele, logic [1:0] ref_b, logic cpg,
                                   logic [2:0] alt);
    res_t r;
    r.ok    = 1'b1;
    r.alt   = alt;
    r.state = STATE_UNKNOWN;
    r.flag  = 1'b0;
    if (allele[2]) begin
      r.ok = 1'b1;
    end else if (allele[1:0] == ref_b) begin
      r.state = STATE_REF;
      r.flag  = cpg;
    end else if (alt == ALLELE_NONE) begin
      r.alt   = allele;
      r.state = STATE_ALT;
      r.flag  = cpg;
    end else if (alt != allele) begin
      r.ok = 1'b0;
    end else begin
      r.state = STATE_ALT;
      r.flag  = cpg;
    end
    return r;
  endfunction

  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [CNT_W-1:0]   cref_q, cref_d, calt_q, calt_d;
  logic [2:0]         alt_q, alt_d;
  logic               aband_q, aband_d;
  logic               held_valid_q, held_valid_d;
  rec_t               held_q, held_d;
  logic [31:0]        prev_pos_q, prev_pos_d;
  logic               prev_c_q, prev_c_d;

  logic [DEPTH_W-1:0] a_depth;
  logic [CNT_W-1:0]   a_cref, a_calt;
  logic [2:0]         a_alt;
  logic               a_aband;
  logic               b_ok;
  logic [1:0]         b;
  logic [7:0]         q_cap;
  logic               take;
  res_t               r_chimp, r_anc;
  logic               ok, nonempty, pair;
  logic [2:0]         alt_fin;
  rec_t               cur;

  always_comb begin
    b_ok = 1'b1;
    b    = BASE_A;
    case (item_i.base_code)
      CODE_A:  b = BASE_A;
      CODE_C:  b = BASE_C;
      CODE_G:  b = BASE_G;
      CODE_T:  b = BASE_T;
      default: b_ok = 1'b0;
    endcase
    q_cap = (item_i.base_qual > QUAL_CAP) ? QUAL_CAP : item_i.base_qual;
    take  = !item_i.is_gap && b_ok && (q_cap >= cfg_i.min_base_qual);

    a_depth = depth_q;
    a_cref  = cref_q;
    a_calt  = calt_q;
    a_alt   = alt_q;
    a_aband = aband_q;
    if (!aband_q && (depth_q < DEPTH_W'(SITE_DEPTH_LIMIT))) begin
      a_depth = depth_q + 1'b1;
      if (take) begin
        if (b == item_i.ref_base) begin
          if (cref_q != COUNT_MAX) a_cref = cref_q + 1'b1;
        end else if ((alt_q == ALLELE_NONE) || (alt_q == {1'b0, b})) begin
          a_alt = {1'b0, b};
          if (calt_q != COUNT_MAX) a_calt = calt_q + 1'b1;
        end else begin
          a_aband = 1'b1;
        end
      end
    end

    r_chimp = resolve(item_i.chimp_allele, item_i.ref_base, item_i.outgroup_cpg, a_alt);
    r_anc   = resolve(item_i.ancestor_allele, item_i.ref_base, item_i.outgroup_cpg,
                      r_chimp.alt);
    ok       = !cfg_i.outgroup_enabled || (r_chimp.ok && r_anc.ok);
    nonempty = (a_cref != '0) || (a_calt != '0);
    if (!cfg_i.outgroup_enabled || a_aband || !nonempty || !r_chimp.ok) begin
      alt_fin = a_alt;
    end else if (!r_anc.ok) begin
      alt_fin = r_chimp.alt;
    end else begin
      alt_fin = r_anc.alt;
    end

    cur.chrom = item_i.chrom_index;
    cur.pos   = item_i.position;
    cur.ref_b = item_i.ref_base;
    cur.alt   = alt_fin;
    cur.rs    = cfg_i.outgroup_enabled ? r_chimp.state : STATE_UNKNOWN;
    cur.rc    = cfg_i.outgroup_enabled & r_chimp.flag;
    cur.as_st = cfg_i.outgroup_enabled ? r_anc.state : STATE_UNKNOWN;
    cur.ac    = cfg_i.outgroup_enabled & r_anc.flag;
    cur.nref  = a_cref;
    cur.nalt  = a_calt;

    pair = held_valid_q && (prev_pos_q == (item_i.position - 32'd1)) && prev_c_q &&
           ((item_i.ref_base == BASE_G) || (alt_fin == ALLELE_G));

    depth_d      = depth_q;
    cref_d       = cref_q;
    calt_d       = calt_q;
    alt_d        = alt_q;
    aband_d      = aband_q;
    held_valid_d = held_valid_q;
    held_d       = held_q;
    prev_pos_d   = prev_pos_q;
    prev_c_d     = prev_c_q;
    push_o.n     = 2'd0;
    push_o.beat0 = make_beat(held_q, 1'b0, 1'b1);
    push_o.beat1 = make_beat(cur, 1'b1, 1'b1);

    if (item_valid_i) begin
      if (item_i.op == OP_FLUSH) begin
        push_o.n     = {1'b0, held_valid_q};
        held_valid_d = 1'b0;
        depth_d      = '0;
        cref_d       = '0;
        calt_d       = '0;
        alt_d        = ALLELE_NONE;
        aband_d      = 1'b0;
      end else if (item_i.last_of_site) begin
        if (!a_aband) begin
          if (nonempty) begin
            if (ok) begin
              if (pair) begin
                push_o.beat0 = make_beat(held_q, 1'b1, 1'b0);
                push_o.n     = 2'd2;
                held_valid_d = 1'b0;
              end else begin
                push_o.n     = {1'b0, held_valid_q};
                held_d       = cur;
                held_valid_d = 1'b1;
              end
            end
          end else begin
            push_o.n     = {1'b0, held_valid_q};
            held_valid_d = 1'b0;
          end
        end
        prev_pos_d = item_i.position;
        prev_c_d   = (item_i.ref_base == BASE_C) || (alt_fin == ALLELE_C);
        depth_d    = '0;
        cref_d     = '0;
        calt_d     = '0;
        alt_d      = ALLELE_NONE;
        aband_d    = 1'b0;
      end else begin
        depth_d = a_depth;
        cref_d  = a_cref;
        calt_d  = a_calt;
        alt_d   = a_alt;
        aband_d = a_aband;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q      <= '0;
      cref_q       <= '0;
      calt_q       <= '0;
      alt_q        <= ALLELE_NONE;
      aband_q      <= 1'b0;
      held_valid_q <= 1'b0;
      prev_pos_q   <= '0;
      prev_c_q     <= 1'b0;
    end else begin
      depth_q      <= depth_d;
      cref_q       <= cref_d;
      calt_q       <= calt_d;
      alt_q        <= alt_d;
      aband_q      <= aband_d;
      held_valid_q <= held_valid_d;
      prev_pos_q   <= prev_pos_d;
      prev_c_q     <= prev_c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

>>> design/pac_outq.sv
// ----------------------------------------------------------------------------
// pac_outq
// Four-entry result queue; takes up to two records a cycle, sends one beat when out_stall_i is low.
// ----------------------------------------------------------------------------
module pac_outq import pac_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  push_t             push_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output out_beat_t         out_data_o,
  output logic [FCNT_W-1:0] count_o
);

  out_beat_t         mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FCNT_W-1:0] count_q, count_d;
  logic              pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign count_o     = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.n);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + FCNT_W'(push_i.n) - FCNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.beat0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= push_i.beat1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> design/pileup_allele_count_cpg.sv
// ----------------------------------------------------------------------------
// pileup_allele_count_cpg
// Pileup allele counter with outgroup resolution and CpG pair marking.
//
// Input channel: one pileup base (or a flush) per beat on in_valid_i/in_data_i,
// taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: one site record per beat on out_valid_o/out_data_o, taken
// when out_stall_i is low. A site record comes out when the site's last base
// (or a later site, or a flush) releases it; out_data_o.last marks the final
// record caused by one input beat.
// Path: an accepted beat is held in the input register, its records enter the
// four-entry result queue at the next edge and then wait their turn there.
// Throughput: one beat per cycle while the queue has room for two more
// records; in_stall_o rises when it does not.
// A stalled receiver fills the queue and then stalls the input.
// Configuration: cfg_we_i writes min_base_qual (index 0) or outgroup_enabled
// (index 1) from cfg_data_i; write only while the block is idle.
// Reset clears site counters, the hold, the queue and both registers.
// ----------------------------------------------------------------------------
module pileup_allele_count_cpg import pac_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t              cfg_q;
  logic              item_valid_q;
  in_beat_t          item_q;
  push_t             push;
  logic [FCNT_W-1:0] fifo_count;
  logic              accept;

  assign in_stall_o = (fifo_count + FCNT_W'(push.n)) > FCNT_W'(FIFO_DEPTH - 2);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_base_qual    <= '0;
      cfg_q.outgroup_enabled <= 1'b0;
      item_valid_q           <= 1'b0;
    end else begin
      item_valid_q <= accept;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MIN_QUAL:    cfg_q.min_base_qual    <= cfg_data_i;
          CFG_OUTGROUP_EN: cfg_q.outgroup_enabled <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  pac_site u_site (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid_q),
    .item_i       (item_q),
    .cfg_i        (cfg_q),
    .push_o       (push)
  );

  pac_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .count_o     (fifo_count)
  );

endmodule

>>> sim/pileup_allele_count_cpg_test.sv
// ----------------------------------------------------------------------------
// pileup_allele_count_cpg_test
// Self-checking testbench for the pileup allele counter. A driver streams
// pileup beats from a queue, a predictor counts alleles, resolves the outgroup
// and pairs CpG sites to build the expected site records, and a monitor
// compares each record field by field. Directed sites cover the special cases
// and the depth limit; random sites, mixed with noise beats and flushes, run
// under six register settings, with random idle and stall on both sides in all but one.
// ----------------------------------------------------------------------------
module pileup_allele_count_cpg_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pac_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 10;
  localparam int RAND_PHASE_ITEMS = 30;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_beat_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_beat_t  out_data_o;
  logic       cfg_we_i = 1'b0;
  logic       cfg_index_i = CFG_MIN_QUAL;
  logic [7:0] cfg_data_i = '0;

  // register shadows
  logic [7:0] min_qual = '0;
  logic       outgroup_on = 1'b0;

  // site and hold state of the predictor
  logic [DEPTH_W-1:0] depth_seen = '0;
  logic [CNT_W-1:0]   ref_run = '0;
  logic [CNT_W-1:0]   alt_run = '0;
  logic [2:0]         site_alt = ALLELE_NONE;
  logic               abandoned = 1'b0;
  logic               held_ok = 1'b0;
  out_beat_t          held_rec = '0;
  logic [31:0]        prev_pos = '0;
  logic               prev_c = 1'b0;

  in_beat_t  pending_q[$];
  out_beat_t expected_q[$];
  out_beat_t want_rec;

  // site context for stimulus generation
  logic [15:0] s_chrom = '0;
  logic [31:0] s_pos = 32'd1;
  logic [1:0]  s_ref = BASE_A;
  logic [2:0]  s_chimp = ALLELE_NONE;
  logic [2:0]  s_anc = ALLELE_NONE;
  logic        s_cpg = 1'b0;

  int beats_in = 0;
  int flushes_in = 0;
  int records_out = 0;
  int cpg_pairs = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int idle_pct = 35;
  int stall_pct = 35;

  pileup_allele_count_cpg dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("pileup_allele_count_cpg regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  task automatic clear_site();
    depth_seen = '0;
    ref_run = '0;
    alt_run = '0;
    site_alt = ALLELE_NONE;
    abandoned = 1'b0;
  endtask

  task automatic queue_record(input out_beat_t r, input logic cpg, input logic fin);
    out_beat_t e;
    e = r;
    e.sample_cpg = cpg;
    e.last = fin;
    expected_q = {expected_q, e};
  endtask

  // returns 0 when the outgroup allele is a third allele
  function automatic logic resolve_allele(input logic [2:0] allele, input logic [1:0] refb,
                                          input logic flag_in, inout logic [2:0] alt,
                                          output logic [1:0] st, output logic flag);
    st = STATE_UNKNOWN;
    flag = 1'b0;
    if (allele > 3'd3) return 1'b1;
    if (allele == {1'b0, refb}) begin
      st = STATE_REF;
      flag = flag_in;
      return 1'b1;
    end
    if (alt == ALLELE_NONE) alt = allele;
    else if (alt != allele) return 1'b0;
    st = STATE_ALT;
    flag = flag_in;
    return 1'b1;
  endfunction

  task automatic predict_beat(input in_beat_t b);
    logic [1:0] base;
    logic       base_ok;
    logic [7:0] q;
    logic [2:0] alt;
    logic       ok;
    logic [1:0] rs, as_st;
    logic       rc, ac;
    out_beat_t  rec;
    if (b.op == OP_FLUSH) begin
      flushes_in++;
      if (held_ok) queue_record(held_rec, 1'b0, 1'b1);
      held_ok = 1'b0;
      clear_site();
      return;
    end
    if (!abandoned && depth_seen < SITE_DEPTH_LIMIT) begin
      depth_seen++;
      base_ok = 1'b1;
      base = BASE_A;
      case (b.base_code)
        CODE_A: base = BASE_A;
        CODE_C: base = BASE_C;
        CODE_G: base = BASE_G;
        CODE_T: base = BASE_T;
        default: base_ok = 1'b0;
      endcase
      q = (b.base_qual > QUAL_CAP) ? QUAL_CAP : b.base_qual;
      if (!b.is_gap && base_ok && q >= min_qual) begin
        if (base == b.ref_base) begin
          if (ref_run != COUNT_MAX) ref_run++;
        end else if (site_alt == ALLELE_NONE || site_alt == {1'b0, base}) begin
          site_alt = {1'b0, base};
          if (alt_run != COUNT_MAX) alt_run++;
        end else begin
          abandoned = 1'b1;
        end
      end
    end
    if (!b.last_of_site) return;

    alt = site_alt;
    if (!abandoned) begin
      if (ref_run != 0 || alt_run != 0) begin
        ok = 1'b1;
        rec = '0;
        if (outgroup_on) begin
          ok = resolve_allele(b.chimp_allele, b.ref_base, b.outgroup_cpg, alt, rs, rc);
          rec.root_state = rs;
          rec.root_cpg = rc;
          if (ok) begin
            ok = resolve_allele(b.ancestor_allele, b.ref_base, b.outgroup_cpg, alt, as_st, ac);
            rec.anc_state = as_st;
            rec.anc_cpg = ac;
          end
        end
        if (ok) begin
          rec.out_chrom = b.chrom_index;
          rec.out_position = b.position;
          rec.out_ref = b.ref_base;
          rec.out_alt = alt;
          rec.ref_count = ref_run;
          rec.alt_count = alt_run;
          if (held_ok && prev_pos == b.position - 32'd1 && prev_c &&
              (b.ref_base == BASE_G || alt == ALLELE_G)) begin
            queue_record(held_rec, 1'b1, 1'b0);
            queue_record(rec, 1'b1, 1'b1);
            held_ok = 1'b0;
            cpg_pairs++;
          end else begin
            if (held_ok) queue_record(held_rec, 1'b0, 1'b1);
            held_rec = rec;
            held_ok = 1'b1;
          end
        end
      end else begin
        if (held_ok) queue_record(held_rec, 1'b0, 1'b1);
        held_ok = 1'b0;
      end
    end
    prev_pos = b.position;
    prev_c = (b.ref_base == BASE_C || alt == ALLELE_C);
    clear_site();
  endtask

  // ------------------------------------------------------------ driver/monitor

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_beat(in_data_i);
        beats_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data_i <= pending_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("record with no expectation at position %0h", out_data_o.out_position);
        err_cnt++;
      end else begin
        want_rec = expected_q.pop_front();
        check_field("out_chrom", want_rec.out_chrom, out_data_o.out_chrom);
        check_field("out_position", want_rec.out_position, out_data_o.out_position);
        check_field("out_ref", want_rec.out_ref, out_data_o.out_ref);
        check_field("out_alt", want_rec.out_alt, out_data_o.out_alt);
        check_field("root_state", want_rec.root_state, out_data_o.root_state);
        check_field("root_cpg", want_rec.root_cpg, out_data_o.root_cpg);
        check_field("anc_state", want_rec.anc_state, out_data_o.anc_state);
        check_field("anc_cpg", want_rec.anc_cpg, out_data_o.anc_cpg);
        check_field("ref_count", want_rec.ref_count, out_data_o.ref_count);
        check_field("alt_count", want_rec.alt_count, out_data_o.alt_count);
        check_field("sample_cpg", want_rec.sample_cpg, out_data_o.sample_cpg);
        check_field("last", want_rec.last, out_data_o.last);
        records_out++;
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // ----------------------------------------------------------------- stimulus

  task automatic open_site(input logic [15:0] c, input logic [31:0] p, input logic [1:0] rb,
                           input logic [2:0] ch, input logic [2:0] an, input logic cg);
    s_chrom = c;
    s_pos = p;
    s_ref = rb;
    s_chimp = ch;
    s_anc = an;
    s_cpg = cg;
  endtask

  function automatic in_beat_t site_item(input logic [3:0] code, input logic [7:0] qual,
                                         input logic gap, input logic fin);
    in_beat_t x;
    x.op = OP_BASE;
    x.chrom_index = s_chrom;
    x.position = s_pos;
    x.ref_base = s_ref;
    x.chimp_allele = s_chimp;
    x.ancestor_allele = s_anc;
    x.outgroup_cpg = s_cpg;
    x.base_code = code;
    x.base_qual = qual;
    x.is_gap = gap;
    x.last_of_site = fin;
    return x;
  endfunction

  function automatic in_beat_t noise_item();
    in_beat_t x;
    x = in_beat_t'({$urandom, $urandom, $urandom});
    if (x.position == 0) x.position = 32'd1;
    if (x.chrom_index == 16'hFFFF) x.chrom_index = 16'hFFFE;
    return x;
  endfunction

  task automatic queue_beat(input in_beat_t x);
    pending_q = {pending_q, x};
  endtask

  task automatic push_flush();
    in_beat_t x;
    x = noise_item();
    x.op = OP_FLUSH;
    queue_beat(x);
  endtask

  function automatic logic [2:0] pick_outgroup(input logic [1:0] alt_b);
    int r;
    r = $urandom_range(99);
    if (r < 40) return {1'b0, s_ref};
    if (r < 70) return {1'b0, alt_b};
    if (r < 80) return 3'($urandom_range(3));
    return 3'($urandom_range(4, 7));
  endfunction

  task automatic add_random_chunk();
    int r, nb;
    logic [1:0] alt_b, third_b;
    logic [3:0] code;
    logic [7:0] q;
    in_beat_t   x;
    r = $urandom_range(99);
    if (r < 5) begin
      x = noise_item();
      if (x.op == OP_FLUSH && $urandom_range(1)) x.op = OP_BASE;
      queue_beat(x);
      return;
    end
    if (r < 8) begin
      push_flush();
      return;
    end
    r = $urandom_range(99);
    if (r < 70) s_pos = s_pos + 32'd1;
    else if (r < 92) s_pos = s_pos + 32'($urandom_range(2, 40));
    else s_pos = $urandom;
    if (s_pos == 0) s_pos = 32'd1;
    if ($urandom_range(99) < 5) s_chrom = 16'($urandom_range(65534));
    r = $urandom_range(99);
    s_ref = (r < 25) ? BASE_C : (r < 50) ? BASE_G : 2'($urandom_range(3));
    alt_b = s_ref + 2'($urandom_range(1, 3));
    do third_b = 2'($urandom_range(3)); while (third_b == s_ref || third_b == alt_b);
    s_chimp = pick_outgroup(alt_b);
    s_anc = pick_outgroup(alt_b);
    s_cpg = 1'($urandom_range(1));
    nb = $urandom_range(0, 6);
    for (int i = 0; i <= nb; i++) begin
      r = $urandom_range(99);
      if (r < 55) code = CODE_A << s_ref;
      else if (r < 80) code = CODE_A << alt_b;
      else if (r < 85) code = CODE_A << third_b;
      else if (r < 92) do code = 4'($urandom_range(15)); while ($countones(code) == 1);
      else code = 4'($urandom_range(15));
      if ($urandom_range(99) < 30) q = min_qual - 8'd1 + 8'($urandom_range(2));
      else q = 8'($urandom_range(255));
      x = site_item(code, q, $urandom_range(99) < 8, i == nb);
      if (i != nb) begin
        x.chimp_allele = 3'($urandom_range(7));
        x.ancestor_allele = 3'($urandom_range(7));
        x.outgroup_cpg = 1'($urandom_range(1));
        if ($urandom_range(99) < 5) x.ref_base = 2'($urandom_range(3));
      end
      queue_beat(x);
    end
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MIN_QUAL) min_qual = val;
    else outgroup_on = val[0];
    @(negedge clk_i);
  endtask

  initial begin
    logic [7:0] phase_qual[6];
    logic       phase_og[6];
    phase_qual = '{8'd0, 8'd20, 8'd64, 8'd65, 8'd255, 8'($urandom_range(1, 63))};
    phase_og = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // registers at reset values: counting, drops, abandon, hold and CpG pairing
    push_flush();
    open_site(16'd0, 32'd100, BASE_C, 3'd4, 3'd4, 1'b0);
    queue_beat(site_item(CODE_C, 8'd255, 1'b1, 1'b0));
    queue_beat(site_item(4'd0, 8'd40, 1'b0, 1'b0));
    queue_beat(site_item(4'd15, 8'd40, 1'b0, 1'b0));
    queue_beat(site_item(CODE_C, 8'd0, 1'b0, 1'b0));
    queue_beat(site_item(CODE_G, 8'd255, 1'b0, 1'b1));
    open_site(16'd0, 32'd101, BASE_G, 3'd4, 3'd4, 1'b0);
    queue_beat(site_item(CODE_G, 8'd30, 1'b0, 1'b1));
    open_site(16'd0, 32'd200, BASE_A, 3'd4, 3'd4, 1'b0);
    queue_beat(site_item(CODE_T, 8'd30, 1'b0, 1'b0));
    queue_beat(site_item(CODE_C, 8'd30, 1'b0, 1'b0));
    queue_beat(site_item(CODE_A, 8'd30, 1'b0, 1'b1));
    open_site(16'd0, 32'd250, BASE_T, 3'd4, 3'd4, 1'b0);
    queue_beat(site_item(CODE_T, 8'd30, 1'b0, 1'b1));
    open_site(16'd0, 32'd300, BASE_A, 3'd4, 3'd4, 1'b0);
    queue_beat(site_item(CODE_A, 8'd30, 1'b1, 1'b1));
    open_site(16'd65534, 32'hFFFF_FFFF, BASE_C, 3'd7, 3'd0, 1'b1);
    queue_beat(site_item(CODE_C, 8'd64, 1'b0, 1'b1));
    open_site(16'd0, 32'd1, BASE_G, 3'd4, 3'd4, 1'b0);
    queue_beat(site_item(CODE_G, 8'd65, 1'b0, 1'b1));
    open_site(16'd0, 32'd400, BASE_C, 3'd4, 3'd4, 1'b0);
    queue_beat(site_item(CODE_C, 8'd10, 1'b0, 1'b0));
    push_flush();
    open_site(16'd0, 32'd500, BASE_A, 3'd4, 3'd4, 1'b0);
    queue_beat(site_item(CODE_C, 8'd10, 1'b0, 1'b1));
    open_site(16'd0, 32'd501, BASE_T, 3'd4, 3'd4, 1'b0);
    queue_beat(site_item(CODE_G, 8'd10, 1'b0, 1'b1));
    open_site(16'd3, 32'd600, BASE_C, 3'd4, 3'd4, 1'b0);
    queue_beat(site_item(CODE_C, 8'd10, 1'b0, 1'b1));
    open_site(16'd7, 32'd601, BASE_G, 3'd4, 3'd4, 1'b0);
    queue_beat(site_item(CODE_G, 8'd10, 1'b0, 1'b1));
    wait_idle();

    // quality threshold and outgroup resolution
    write_reg(CFG_MIN_QUAL, 8'd30);
    write_reg(CFG_OUTGROUP_EN, 8'd1);
    open_site(16'd1, 32'd700, BASE_A, 3'd0, 3'd3, 1'b1);
    queue_beat(site_item(CODE_A, 8'd29, 1'b0, 1'b0));
    queue_beat(site_item(CODE_A, 8'd30, 1'b0, 1'b0));
    queue_beat(site_item(CODE_A, 8'd200, 1'b0, 1'b1));
    open_site(16'd1, 32'd710, BASE_C, 3'd4, 3'd7, 1'b1);
    queue_beat(site_item(CODE_C, 8'd40, 1'b0, 1'b1));
    open_site(16'd1, 32'd720, BASE_G, 3'd0, 3'd2, 1'b0);
    queue_beat(site_item(CODE_T, 8'd40, 1'b0, 1'b1));
    open_site(16'd1, 32'd730, BASE_A, 3'd3, 3'd1, 1'b1);
    queue_beat(site_item(CODE_T, 8'd40, 1'b0, 1'b1));
    open_site(16'd1, 32'd740, BASE_C, 3'd2, 3'd1, 1'b1);
    queue_beat(site_item(CODE_C, 8'd40, 1'b0, 1'b1));
    open_site(16'd1, 32'd741, BASE_A, 3'd2, 3'd5, 1'b0);
    queue_beat(site_item(CODE_A, 8'd40, 1'b0, 1'b1));
    push_flush();
    wait_idle();

    // depth limit: beats past SITE_DEPTH_LIMIT are ignored, even a third allele
    write_reg(CFG_MIN_QUAL, 8'd0);
    write_reg(CFG_OUTGROUP_EN, 8'd0);
    open_site(16'd9, 32'd5000, BASE_A, 3'd4, 3'd4, 1'b0);
    for (int k = 0; k < SITE_DEPTH_LIMIT + 6; k++) begin
      queue_beat(site_item(
          (k >= SITE_DEPTH_LIMIT) ? CODE_C : ($urandom_range(9) < 7) ? CODE_A : CODE_T,
          8'($urandom_range(255)), $urandom_range(99) < 5, k == SITE_DEPTH_LIMIT + 5));
    end
    open_site(16'd9, 32'd5001, BASE_G, 3'd4, 3'd4, 1'b0);
    queue_beat(site_item(CODE_G, 8'd5, 1'b0, 1'b1));
    push_flush();
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_MIN_QUAL, phase_qual[ph]);
      write_reg(CFG_OUTGROUP_EN, {7'd0, phase_og[ph]});
      idle_pct = (ph == 2) ? 0 : 35;
      stall_pct = (ph == 2) ? 0 : 35;
      while (pending_q.size() < RAND_PHASE_ITEMS) add_random_chunk();
      wait_idle();
    end

    $display("covered %0d beats (%0d flushes), %0d records checked, %0d CpG pairs,",
             beats_in, flushes_in, records_out, cpg_pairs);
    $display("over eight register settings including the depth limit and idle stretches");
    if (err_cnt == 0) begin
      $display("pileup_allele_count_cpg regression: pass");
    end else begin
      $display("pileup_allele_count_cpg regression: fail");
    end
    $finish;
  end

endmodule
